/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the sorted set block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the default clock and reset of the module
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/sslt_pkg.sv */
// Package of the sorted set table: item types, walk token, codes and sizes
package sslt_pkg;

  // Default number of table entries
  localparam int unsigned CAPACITY = 16;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] element_count;
  } out_item_t;

  // Contents of one cell
  typedef struct packed {
    logic               occ;
    logic signed [31:0] elem;
  } slot_t;

  // Walk token handed from cell to cell
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic               desc;   // descending order for this walk
    logic               ins;    // room left for an insert
    logic               stop;   // walk has reached its stop point
    logic               hit;    // value met (search/add) or removed
    logic               shift;  // insert done, carry moving right
    slot_t              carry;
  } tok_t;

endpackage

/* src/sslt_cell.sv */
// One cell of the sorted chain: holds one list position and acts on the passing token
module sslt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_vld_i,
  input  sslt_pkg::tok_t tok_i,
  input  sslt_pkg::slot_t nb_i,
  output logic          tok_vld_o,
  output sslt_pkg::tok_t tok_o,
  output sslt_pkg::slot_t slot_o
);

  logic               occ_q, occ_d;
  logic signed [31:0] elem_q, elem_d;
  logic               tok_vld_q;
  sslt_pkg::tok_t     tok_q, tok_d;

  // Cell update and token rewrite for the passing item
  always_comb begin
    logic prec;
    prec   = tok_i.desc ? (elem_q >= tok_i.value) : (elem_q <= tok_i.value);
    occ_d  = occ_q;
    elem_d = elem_q;
    tok_d  = tok_i;
    case (tok_i.cmd)
      sslt_pkg::CMD_ADD, sslt_pkg::CMD_SEARCH: begin
        if (!tok_i.stop) begin
          if (occ_q && prec) begin
            if (elem_q == tok_i.value) tok_d.hit = 1'b1;
          end else begin
            tok_d.stop = 1'b1;
            // insert here, old contents move on as the carry
            if ((tok_i.cmd == sslt_pkg::CMD_ADD) && tok_i.ins && !tok_i.hit) begin
              occ_d          = 1'b1;
              elem_d         = tok_i.value;
              tok_d.shift    = 1'b1;
              tok_d.carry    = '{occ: occ_q, elem: elem_q};
            end
          end
        end else if (tok_i.shift) begin
          occ_d       = tok_i.carry.occ;
          elem_d      = tok_i.carry.elem;
          tok_d.carry = '{occ: occ_q, elem: elem_q};
        end
      end
      sslt_pkg::CMD_REMOVE: begin
        // first match is dropped, later cells pull from the right
        if (tok_i.hit || (occ_q && (elem_q == tok_i.value))) begin
          tok_d.hit = 1'b1;
          occ_d     = nb_i.occ;
          elem_d    = nb_i.elem;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy and token valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (tok_vld_i) occ_q <= occ_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      elem_q <= elem_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;
  assign slot_o    = '{occ: occ_q, elem: elem_q};

endmodule

/* src/sorted_set_linked_table.sv */
// Top level of the sorted set table: command intake, cell chain, result output
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (command, value)
//  out     | output    | out_valid_o/out_stall_i | out_item_o (status, element_count)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (order_descending)
//
// An item passes the launch register, then one cell register per cell as the token
// walks the chain of CAPACITY cells, then the output register. The input stalls
// while an item is in the chain, so only one item is in flight at a time.
// After reset every cell is empty, the count is zero and the order is ascending.
// While a result waits on out_stall_i, one more item can finish into a holding
// register; the input then stalls until the output drains.
`include "assert_macros.svh"

module sorted_set_linked_table #(
  parameter int unsigned CAPACITY = sslt_pkg::CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sslt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sslt_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                cfg_desc_q;
  logic                busy_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q;
  sslt_pkg::out_item_t out_q;
  logic                held_vld_q;
  sslt_pkg::out_item_t held_q;

  logic                tv [CAPACITY+1];
  sslt_pkg::tok_t      tk [CAPACITY+1];
  sslt_pkg::slot_t     sl [CAPACITY+1];

  logic                accept, take, exit_vld;
  sslt_pkg::tok_t      ex;
  sslt_pkg::out_item_t res;
  logic [CNT_W+4:0]    cnt_ext;

  assign accept   = in_valid_i && !in_stall_o;
  assign take     = out_valid_q && !out_stall_i;
  assign exit_vld = tv[CAPACITY];
  assign ex       = tk[CAPACITY];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      cfg_desc_q <= cfg_wdata_i;
    end
  end

  // Launch register feeding the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv[0] <= 1'b0;
    end else begin
      tv[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tk[0] <= '{cmd:   in_item_i.command,
                 value: in_item_i.value,
                 desc:  cfg_desc_q,
                 ins:   (count_q != CNT_W'(CAPACITY)),
                 stop:  1'b0,
                 hit:   1'b0,
                 shift: 1'b0,
                 carry: '0};
    end
  end

  // Chain of cells, one per list position
  assign sl[CAPACITY] = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    sslt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (tv[k]),
      .tok_i     (tk[k]),
      .nb_i      (sl[k+1]),
      .tok_vld_o (tv[k+1]),
      .tok_o     (tk[k+1]),
      .slot_o    (sl[k])
    );
  end

  // Status and new count from the token leaving the chain
  always_comb begin
    res.status = sslt_pkg::ST_MISS;
    count_d    = count_q;
    case (ex.cmd)
      sslt_pkg::CMD_ADD: begin
        if (ex.hit) begin
          res.status = sslt_pkg::ST_MISS;
        end else if (!ex.ins) begin
          res.status = sslt_pkg::ST_FULL;
        end else begin
          res.status = sslt_pkg::ST_OK;
          count_d    = count_q + CNT_W'(1);
        end
      end
      sslt_pkg::CMD_REMOVE: begin
        if (ex.hit) begin
          res.status = sslt_pkg::ST_OK;
          count_d    = count_q - CNT_W'(1);
        end
      end
      sslt_pkg::CMD_SEARCH: begin
        res.status = ex.hit ? sslt_pkg::ST_OK : sslt_pkg::ST_MISS;
      end
      default: begin
        res.status = sslt_pkg::ST_MISS;
      end
    endcase
    cnt_ext           = {5'd0, count_d};
    res.element_count = cnt_ext[4:0];
  end

  // Busy flag, count and output side control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      held_vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exit_vld) begin
        busy_q <= 1'b0;
      end
      if (exit_vld) begin
        count_q <= count_d;
        if (!out_valid_q || take) begin
          out_valid_q <= 1'b1;
        end else begin
          held_vld_q <= 1'b1;
        end
      end else if (take) begin
        if (held_vld_q) begin
          held_vld_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (exit_vld) begin
      if (!out_valid_q || take) begin
        out_q <= res;
      end else begin
        held_q <= res;
      end
    end else if (take && held_vld_q) begin
      out_q <= held_q;
    end
  end

  assign in_stall_o  = busy_q || held_vld_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `ASSERT_DEF(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_DEF(a_exit_busy, exit_vld |-> busy_q, "token left the chain while idle")
  `ASSERT_DEF(a_exit_room, exit_vld |-> !held_vld_q, "result arrived with holding register full")
  `ASSERT_DEF(a_add_count,
              (exit_vld && (ex.cmd == sslt_pkg::CMD_ADD) && (res.status == sslt_pkg::ST_OK))
              |=> (count_q == $past(count_q) + CNT_W'(1)),
              "successful add did not raise the count")

endmodule

/* bench/sslt_checker.sv */
// Checker for the sorted set table: watches both channels, predicts each result and compares
module sslt_checker #(
  parameter int unsigned TABLE_DEPTH = sslt_pkg::CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sslt_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sslt_pkg::out_item_t out_item_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  import sslt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH + 1);
  typedef logic [IW-1:0] link_t;
  // null link is one past the last entry
  localparam link_t NIL = link_t'(TABLE_DEPTH);

  // predicted table: element values, links, list and free chain heads
  logic signed [31:0] cell_value [TABLE_DEPTH];
  link_t              cell_next  [TABLE_DEPTH];
  link_t              chain_head;
  link_t              spare_head;
  link_t              member_count;
  logic               descending;

  out_item_t awaited_results [$];

  function automatic void clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_value[i] = '0;
      cell_next[i]  = link_t'(i + 1);
    end
    chain_head   = NIL;
    spare_head   = '0;
    member_count = '0;
    descending   = 1'b0;
  endfunction

  // a may stand before b under the order in force
  function automatic logic ahead_of(logic signed [31:0] a, logic signed [31:0] b);
    return descending ? (a >= b) : (a <= b);
  endfunction

  // walk stops at the first element that no longer comes ahead of v
  function automatic logic holds_value(logic signed [31:0] v);
    link_t cur;
    int    steps;
    cur   = chain_head;
    steps = 0;
    while (cur < NIL && steps < TABLE_DEPTH && ahead_of(cell_value[cur], v)) begin
      if (cell_value[cur] == v) return 1'b1;
      cur = cell_next[cur];
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] insert_value(logic signed [31:0] v);
    link_t slot, cur, prev;
    int    steps;
    if (holds_value(v)) return ST_MISS;
    if (member_count >= TABLE_DEPTH || spare_head >= NIL) return ST_FULL;
    slot             = spare_head;
    spare_head       = cell_next[slot];
    cell_value[slot] = v;
    cur   = chain_head;
    prev  = NIL;
    steps = 0;
    while (cur < NIL && steps < TABLE_DEPTH && ahead_of(cell_value[cur], v)) begin
      prev = cur;
      cur  = cell_next[cur];
      steps++;
    end
    cell_next[slot] = cur;
    if (prev >= NIL) chain_head = slot;
    else cell_next[prev] = slot;
    member_count++;
    return ST_OK;
  endfunction

  // removal ignores the order and walks the list until the first match or its end
  function automatic logic [1:0] drop_value(logic signed [31:0] v);
    link_t cur, prev;
    int    steps;
    cur   = chain_head;
    prev  = NIL;
    steps = 0;
    while (cur < NIL && steps < TABLE_DEPTH) begin
      if (cell_value[cur] == v) begin
        if (prev >= NIL) chain_head = cell_next[cur];
        else cell_next[prev] = cell_next[cur];
        cell_next[cur] = spare_head;
        spare_head     = cur;
        if (member_count > 0) member_count--;
        return ST_OK;
      end
      prev = cur;
      cur  = cell_next[cur];
      steps++;
    end
    return ST_MISS;
  endfunction

  function automatic out_item_t apply_set_command(in_item_t item);
    out_item_t res;
    case (item.command)
      CMD_ADD:    res.status = insert_value(item.value);
      CMD_REMOVE: res.status = drop_value(item.value);
      CMD_SEARCH: res.status = holds_value(item.value) ? ST_OK : ST_MISS;
      default:    res.status = ST_MISS;
    endcase
    res.element_count = 5'(member_count);
    return res;
  endfunction

  // compare the delivered result first, then predict the newly taken item
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    if (!rst_ni) begin
      clear_table();
      awaited_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) descending = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with none awaited: status %0d, element_count %0d",
                 out_item_i.status, out_item_i.element_count);
          fail_count_o++;
        end else begin
          exp = awaited_results.pop_front();
          if (out_item_i.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, out_item_i.status);
            fail_count_o++;
          end
          if (out_item_i.element_count !== exp.element_count) begin
            $error("element_count: expected %0d, actual %0d",
                   exp.element_count, out_item_i.element_count);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) awaited_results.push_back(apply_set_command(in_item_i));
      pending_o = awaited_results.size();
    end
  end

endmodule

/* bench/sorted_set_linked_table_tb.sv */
// Top of the sorted set table testbench: clock, reset, stimulus, idling and verdict
module sorted_set_linked_table_tb;
  import sslt_pkg::*;

  // command code the block must answer as a miss
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         POOL_SIZE   = 24;
  localparam int         PHASE_ITEMS = 150;
  localparam int         SETTLE      = CAPACITY + 4;
  localparam int         CYCLE_LIMIT = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;

  int pending;
  int fail_count;
  int idle_pct;
  int stall_pct;
  int add_pct;
  int cycle_count;

  logic signed [31:0] pool [POOL_SIZE];

  sorted_set_linked_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sslt_checker #(.TABLE_DEPTH(CAPACITY)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // offer one item; returns at the edge that takes it
  task automatic send_item(input logic [1:0] cmd, input logic signed [31:0] val);
    in_item_t item;
    item.command = cmd;
    item.value   = val;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold off the sender until every awaited result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // order register is only touched with the table idle
  task automatic set_order(input logic desc);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= desc;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly well-known values so that hits, duplicates and a full table all happen
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(9) == 0) return $urandom;
    return pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [1:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r >= 96) return CMD_UNUSED;
    if (r < add_pct) return CMD_ADD;
    return ($urandom_range(1) != 0) ? CMD_REMOVE : CMD_SEARCH;
  endfunction

  // random commands, add weight redrawn every 32 items, drain halfway through
  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) add_pct = $urandom_range(70, 30);
      if (i == n / 2) drain();
      send_item(pick_command(), pick_value());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    add_pct     = 50;
    cycle_count = 0;
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7FFF_FFFF;
    pool[2] = 32'sh0;
    pool[3] = -32'sd1;
    pool[4] = 32'sd1;
    for (int i = 5; i < POOL_SIZE; i++) pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, unused code, extremes, duplicate, early stop, fill up
    send_item(CMD_SEARCH, pool[0]);
    send_item(CMD_REMOVE, pool[1]);
    send_item(CMD_UNUSED, -32'sd1);
    send_item(CMD_ADD, pool[0]);
    send_item(CMD_ADD, pool[1]);
    send_item(CMD_ADD, pool[2]);
    send_item(CMD_ADD, pool[1]);
    send_item(CMD_SEARCH, pool[2]);
    send_item(CMD_SEARCH, 32'sd5);
    send_item(CMD_REMOVE, pool[2]);
    for (int i = 3; i < 3 + CAPACITY - 2; i++) send_item(CMD_ADD, pool[i]);
    send_item(CMD_ADD, pool[CAPACITY + 1]);

    // no idling, ascending
    run_phase(PHASE_ITEMS);
    // empty the table of known values, then go descending
    for (int i = 0; i < POOL_SIZE; i++) send_item(CMD_REMOVE, pool[i]);
    set_order(1'b1);
    idle_pct = 81;
    run_phase(PHASE_ITEMS);

    // order flipped with elements held
    set_order(1'b0);
    idle_pct  = 0;
    stall_pct = 81;
    run_phase(PHASE_ITEMS);

    set_order(1'b1);
    idle_pct  = 27;
    stall_pct = 27;
    run_phase(PHASE_ITEMS);

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
